FILE: rtl/bftm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bftm_pkg;

    localparam int TAPE_DEPTH_DEF = 32768;
    localparam int PROG_DEPTH_DEF = 4096;

    localparam int LEN_W  = 13;
    localparam int LADR_W = 12;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 3;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_STEP    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_DONE    = 3'd1;
    localparam logic [ST_W-1:0] ST_OPEN    = 3'd2;
    localparam logic [ST_W-1:0] ST_CLOSE   = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic [1:0]        func;
        logic [LADR_W-1:0] load_address;
        logic [BYTE_W-1:0] prog_char;
        logic [BYTE_W-1:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              input_used;
        logic [LEN_W-1:0]  program_counter;
    } t_out;

endpackage

`default_nettype wire

FILE: rtl/bftm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bftm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bf_tape_machine_step.sv
// Eight-command tape machine, one instruction per step transfer.
// Input channel (i_in_valid / o_in_stall) carries func: load writes one
// program character, step executes one instruction, restart clears the tape
// and zeroes the program counter and data pointer. Every input transfer
// gives exactly one output transfer (o_out_valid / i_out_stall).
// i_cfg_we / i_cfg_data set program_length; write it only while idle.
// Steps per item: load and no-op go straight to the response state; a plain
// instruction passes through fetch (program and tape read in parallel from
// registered memories, then write back); a bracket jump then scans the program,
// one program read per cycle. Restart sweeps the tape memory one entry per
// cycle. After reset the same sweep runs with the input stalled and no output
// transfer; configuration writes are taken.
// The result sits in an output register; while the receiver stalls it holds,
// and the block finishes the next item into its result register before waiting.
// An error (unmatched bracket, unknown character) stops the machine; later
// steps repeat that status until restart.
`timescale 1ns / 1ps
`default_nettype none

module bf_tape_machine_step #(
    parameter int TAPE_DEPTH    = bftm_pkg::TAPE_DEPTH_DEF,
    parameter int PROGRAM_DEPTH = bftm_pkg::PROG_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire bftm_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output bftm_pkg::t_out                   o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [bftm_pkg::LEN_W-1:0]  i_cfg_data
);

    import bftm_pkg::*;

    localparam int CW = $clog2(TAPE_DEPTH);
    localparam int PA = $clog2(PROGRAM_DEPTH);
    localparam logic [CW-1:0] CP_LAST = CW'(TAPE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCANF,
        S_SCANB,
        S_CLEAR,
        S_RESP
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_pc, n_pc;
    logic [CW-1:0]    r_cp, n_cp;
    logic             r_stopped, n_stopped;
    logic [ST_W-1:0]  r_stop_code, n_stop_code;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_j, n_j;
    logic [LEN_W-1:0] r_depth, n_depth;
    logic [CW-1:0]    r_clr, n_clr;
    logic             r_clr_resp, n_clr_resp;
    logic [BYTE_W-1:0] r_in_byte, n_in_byte;
    t_out             r_res, n_res;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic [LEN_W-1:0]  w_len;
    logic              w_in_xfer;
    logic              w_prog_we;
    logic [LEN_W-1:0]  w_prog_ra;
    logic [BYTE_W-1:0] w_prog_q;
    logic              w_tape_we;
    logic [CW-1:0]     w_tape_wa;
    logic [BYTE_W-1:0] w_tape_wd;
    logic [BYTE_W-1:0] w_tape_q;
    logic [LEN_W-1:0]  w_nd;

    assign w_len = (32'(r_len) < PROGRAM_DEPTH) ? r_len : LEN_W'(PROGRAM_DEPTH);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_prog_we   = w_in_xfer && (i_in_data.func == FUNC_LOAD)
                         && (32'(i_in_data.load_address) < PROGRAM_DEPTH);

    bftm_ram #(
        .DEPTH (PROGRAM_DEPTH),
        .WIDTH (BYTE_W)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (w_prog_we),
        .i_waddr (PA'(i_in_data.load_address)),
        .i_wdata (i_in_data.prog_char),
        .i_raddr (PA'(w_prog_ra)),
        .o_rdata (w_prog_q)
    );

    bftm_ram #(
        .DEPTH (TAPE_DEPTH),
        .WIDTH (BYTE_W)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (w_tape_we),
        .i_waddr (w_tape_wa),
        .i_wdata (w_tape_wd),
        .i_raddr (r_cp),
        .o_rdata (w_tape_q)
    );

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_cp        = r_cp;
        n_stopped   = r_stopped;
        n_stop_code = r_stop_code;
        n_j         = r_j;
        n_depth     = r_depth;
        n_clr       = r_clr;
        n_clr_resp  = r_clr_resp;
        n_in_byte   = r_in_byte;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_prog_ra   = r_pc;
        w_tape_we   = 1'b0;
        w_tape_wa   = r_cp;
        w_tape_wd   = w_tape_q;
        w_nd        = r_depth;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_res     = '0;
                    n_in_byte = i_in_data.in_byte;
                    n_state   = S_RESP;
                    if (i_in_data.func == FUNC_RESTART) begin
                        n_clr      = '0;
                        n_clr_resp = 1'b1;
                        n_state    = S_CLEAR;
                    end else if (i_in_data.func == FUNC_STEP) begin
                        if (r_stopped) begin
                            n_res.status = r_stop_code;
                        end else if (r_pc >= w_len) begin
                            n_res.status = ST_DONE;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_state = S_RESP;
                n_pc    = r_pc + 1'b1;
                case (w_prog_q)
                    CH_RIGHT: n_cp = (r_cp == CP_LAST) ? '0 : r_cp + 1'b1;
                    CH_LEFT:  n_cp = (r_cp == '0) ? CP_LAST : r_cp - 1'b1;
                    CH_INC: begin
                        w_tape_we = 1'b1;
                        w_tape_wd = w_tape_q + 1'b1;
                    end
                    CH_DEC: begin
                        w_tape_we = 1'b1;
                        w_tape_wd = w_tape_q - 1'b1;
                    end
                    CH_OUT: begin
                        n_res.out_valid = 1'b1;
                        n_res.out_byte  = w_tape_q;
                    end
                    CH_IN: begin
                        w_tape_we        = 1'b1;
                        w_tape_wd        = r_in_byte;
                        n_res.input_used = 1'b1;
                    end
                    CH_OPEN: begin
                        if (w_tape_q == '0) begin
                            n_pc    = r_pc;
                            n_depth = LEN_W'(1);
                            if (r_pc + 1'b1 < w_len) begin
                                n_j       = r_pc + 1'b1;
                                w_prog_ra = n_j;
                                n_state   = S_SCANF;
                            end else begin
                                n_stopped    = 1'b1;
                                n_stop_code  = ST_OPEN;
                                n_res.status = ST_OPEN;
                            end
                        end
                    end
                    CH_CLOSE: begin
                        if (w_tape_q != '0) begin
                            n_pc    = r_pc;
                            n_depth = LEN_W'(1);
                            if (r_pc != '0) begin
                                n_j       = r_pc - 1'b1;
                                w_prog_ra = n_j;
                                n_state   = S_SCANB;
                            end else begin
                                n_stopped    = 1'b1;
                                n_stop_code  = ST_CLOSE;
                                n_res.status = ST_CLOSE;
                            end
                        end
                    end
                    default: begin
                        n_pc         = r_pc;
                        n_stopped    = 1'b1;
                        n_stop_code  = ST_UNKNOWN;
                        n_res.status = ST_UNKNOWN;
                    end
                endcase
            end
            S_SCANF: begin
                if (w_prog_q == CH_CLOSE) begin
                    w_nd = r_depth - 1'b1;
                end else if (w_prog_q == CH_OPEN) begin
                    w_nd = r_depth + 1'b1;
                end
                n_depth = w_nd;
                if (w_nd == '0) begin
                    n_pc    = r_j + 1'b1;
                    n_state = S_RESP;
                end else if (r_j + 1'b1 < w_len) begin
                    n_j       = r_j + 1'b1;
                    w_prog_ra = n_j;
                end else begin
                    n_stopped    = 1'b1;
                    n_stop_code  = ST_OPEN;
                    n_res.status = ST_OPEN;
                    n_state      = S_RESP;
                end
            end
            S_SCANB: begin
                if (w_prog_q == CH_OPEN) begin
                    w_nd = r_depth - 1'b1;
                end else if (w_prog_q == CH_CLOSE) begin
                    w_nd = r_depth + 1'b1;
                end
                n_depth = w_nd;
                if (w_nd == '0) begin
                    n_pc    = r_j + 1'b1;
                    n_state = S_RESP;
                end else if (r_j != '0) begin
                    n_j       = r_j - 1'b1;
                    w_prog_ra = n_j;
                end else begin
                    n_stopped    = 1'b1;
                    n_stop_code  = ST_CLOSE;
                    n_res.status = ST_CLOSE;
                    n_state      = S_RESP;
                end
            end
            S_CLEAR: begin
                w_tape_we = 1'b1;
                w_tape_wa = r_clr;
                w_tape_wd = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CP_LAST) begin
                    n_pc        = '0;
                    n_cp        = '0;
                    n_stopped   = 1'b0;
                    n_stop_code = ST_OK;
                    n_state     = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out                 = r_res;
                    n_out.program_counter = r_pc;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pc        <= '0;
            r_cp        <= '0;
            r_stopped   <= 1'b0;
            r_stop_code <= ST_OK;
            r_len       <= '0;
            r_clr       <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_cp        <= n_cp;
            r_stopped   <= n_stopped;
            r_stop_code <= n_stop_code;
            r_clr       <= n_clr;
            r_clr_resp  <= n_clr_resp;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
        end
        r_j       <= n_j;
        r_depth   <= n_depth;
        r_in_byte <= n_in_byte;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cp) < TAPE_DEPTH)
        else $error("cell pointer beyond tape depth");

    a_stop_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_stop_code == ST_OPEN || r_stop_code == ST_CLOSE
                       || r_stop_code == ST_UNKNOWN))
        else $error("stopped without error code");

    a_scan_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCANF || r_state == S_SCANB) |-> r_depth != '0)
        else $error("bracket scan with zero depth");

    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state != S_IDLE)
        else $error("input transfer did not start work");

endmodule

`default_nettype wire

FILE: tb/bf_tape_machine_step_tb.sv
`timescale 1ns / 1ps

module bf_tape_machine_step_tb;
    import bftm_pkg::*;

    localparam int TAPE_DEPTH  = TAPE_DEPTH_DEF;
    localparam int PROG_DEPTH  = PROG_DEPTH_DEF;
    localparam int RAND_ITEMS  = 750;
    localparam int CYCLE_LIMIT = 16_000_000;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_item   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out             o_out_data;

    bf_tape_machine_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Two copies of the machine: [0] tracks queued items (stimulus planning),
    // [1] tracks accepted transfers and yields the expected results.
    bit [7:0]        tape_m      [0:1][0:TAPE_DEPTH-1];
    bit [7:0]        prog_m      [0:1][0:PROG_DEPTH-1];
    bit              prog_wr     [0:1][0:PROG_DEPTH-1];
    int              ii_m        [0:1];
    int              cp_m        [0:1];
    bit              halted_m    [0:1];
    logic [ST_W-1:0] halt_code_m [0:1];
    int              plen = 0;

    t_in        pending[$];
    t_out       result_q[$];
    logic [7:0] prog_buf[$];
    int         n_queued   = 0;
    int         n_checked  = 0;
    int         fail_count = 0;
    int         cycles     = 0;
    int         gap_left   = 0;
    int         hold_left  = 0;
    bit         calm_in    = 1'b0;
    bit         calm_out   = 1'b0;

    // Returns 1 when the item would read a program entry never written.
    function automatic bit machine_exec(input int k, input t_in it, input bit dry,
                                        output t_out r);
        int ii, cp, cp_new, j, depth, len, i;
        logic [7:0] cur_val, op;
        logic [ST_W-1:0] code;
        bit hazard, stop;
        r = '0;
        hazard = 1'b0;
        stop = 1'b0;
        code = ST_OK;
        ii = ii_m[k];
        cp = cp_m[k];
        cp_new = cp;
        len = (plen < PROG_DEPTH) ? plen : PROG_DEPTH;
        case (it.func)
            FUNC_LOAD: begin
                if (!dry) begin
                    prog_m[k][it.load_address] = it.prog_char;
                    prog_wr[k][it.load_address] = 1'b1;
                end
            end
            FUNC_RESTART: begin
                ii = 0;
                if (!dry) begin
                    for (i = 0; i < TAPE_DEPTH; i++)
                        tape_m[k][i] = 8'd0;
                    ii_m[k] = 0;
                    cp_m[k] = 0;
                    halted_m[k] = 1'b0;
                    halt_code_m[k] = ST_OK;
                end
            end
            FUNC_STEP: begin
                if (halted_m[k]) begin
                    r.status = halt_code_m[k];
                end else if (ii >= len) begin
                    r.status = ST_DONE;
                end else if (!prog_wr[k][ii]) begin
                    hazard = 1'b1;
                end else begin
                    cur_val = tape_m[k][cp];
                    op = prog_m[k][ii];
                    case (op)
                        CH_RIGHT: cp_new = (cp == TAPE_DEPTH - 1) ? 0 : cp + 1;
                        CH_LEFT:  cp_new = (cp == 0) ? TAPE_DEPTH - 1 : cp - 1;
                        CH_INC:   cur_val = cur_val + 8'd1;
                        CH_DEC:   cur_val = cur_val - 8'd1;
                        CH_OUT: begin
                            r.out_valid = 1'b1;
                            r.out_byte = cur_val;
                        end
                        CH_IN: begin
                            cur_val = it.in_byte;
                            r.input_used = 1'b1;
                        end
                        CH_OPEN: begin
                            if (cur_val == 8'd0) begin
                                j = ii;
                                depth = 1;
                                while (depth != 0 && j + 1 < len && !hazard) begin
                                    j++;
                                    if (!prog_wr[k][j])
                                        hazard = 1'b1;
                                    else if (prog_m[k][j] == CH_CLOSE)
                                        depth--;
                                    else if (prog_m[k][j] == CH_OPEN)
                                        depth++;
                                end
                                if (depth != 0) begin
                                    stop = 1'b1;
                                    code = ST_OPEN;
                                end else begin
                                    ii = j;
                                end
                            end
                        end
                        CH_CLOSE: begin
                            if (cur_val != 8'd0) begin
                                j = ii;
                                depth = 1;
                                while (depth != 0 && j > 0 && !hazard) begin
                                    j--;
                                    if (!prog_wr[k][j])
                                        hazard = 1'b1;
                                    else if (prog_m[k][j] == CH_OPEN)
                                        depth--;
                                    else if (prog_m[k][j] == CH_CLOSE)
                                        depth++;
                                end
                                if (depth != 0) begin
                                    stop = 1'b1;
                                    code = ST_CLOSE;
                                end else begin
                                    ii = j;
                                end
                            end
                        end
                        default: begin
                            stop = 1'b1;
                            code = ST_UNKNOWN;
                        end
                    endcase
                    if (stop) begin
                        r = '0;
                        r.status = code;
                        ii = ii_m[k];
                    end else begin
                        ii++;
                    end
                    if (!dry && !hazard) begin
                        if (stop) begin
                            halted_m[k] = 1'b1;
                            halt_code_m[k] = code;
                        end else begin
                            tape_m[k][cp] = cur_val;
                            cp_m[k] = cp_new;
                            ii_m[k] = ii;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.program_counter = ii[LEN_W-1:0];
        return hazard;
    endfunction

    function automatic int gap_len(input bit calm);
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in rand_item(input logic [1:0] fn);
        t_in it;
        it.func = fn;
        it.load_address = LADR_W'($urandom_range(0, PROG_DEPTH - 1));
        it.prog_char = 8'($urandom_range(0, 255));
        it.in_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic queue_item(input t_in it);
        t_out scratch;
        void'(machine_exec(0, it, 1'b0, scratch));
        pending.push_back(it);
        n_queued++;
    endtask

    task automatic queue_load(input int addr, input logic [7:0] ch);
        t_in it;
        it = rand_item(FUNC_LOAD);
        it.load_address = addr[LADR_W-1:0];
        it.prog_char = ch;
        queue_item(it);
    endtask

    // A step is queued only if it reads no unwritten program entry.
    task automatic try_step(input logic [7:0] ib, output bit ok, output t_out r);
        t_in it;
        it = rand_item(FUNC_STEP);
        it.in_byte = ib;
        ok = !machine_exec(0, it, 1'b1, r);
        if (ok)
            queue_item(it);
    endtask

    task automatic drain();
        while (n_checked != n_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length(input int len);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= len[LEN_W-1:0];
        plen = len;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_steps(input int limit);
        int k, bad;
        bit ok;
        t_out r;
        bad = 0;
        for (k = 0; k < limit && bad < 2; k++) begin
            if ($urandom_range(0, 9) == 0)
                queue_item(rand_item($urandom_range(0, 1) ? FUNC_NOP : FUNC_LOAD));
            try_step(8'($urandom_range(0, 255)), ok, r);
            if (!ok)
                break;
            if (r.status != ST_OK)
                bad++;
        end
    endtask

    // Balanced bracket programs; noisy ones get stray brackets and raw bytes.
    task automatic build_program(input bit noisy);
        int n, open, i, p;
        logic [7:0] c;
        prog_buf.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 24);
        open = 0;
        for (i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (noisy && p < 12) begin
                c = (p < 4) ? CH_CLOSE : (p < 8) ? CH_OPEN : 8'($urandom_range(0, 255));
            end else if (p < 22 && n - i > open + 1) begin
                c = CH_OPEN;
                open++;
            end else if (p < 40 && open > 0) begin
                c = CH_CLOSE;
                open--;
            end else begin
                case ($urandom_range(0, 5))
                    0: c = CH_RIGHT;
                    1: c = CH_LEFT;
                    2: c = CH_INC;
                    3: c = CH_DEC;
                    4: c = CH_OUT;
                    default: c = CH_IN;
                endcase
            end
            prog_buf.push_back(c);
        end
        while (open > 0) begin
            prog_buf.push_back(CH_CLOSE);
            open--;
        end
    endtask

    task automatic note_miss(input bit orphan, input t_out want, input t_out got);
        fail_count++;
        if (fail_count <= 10) begin
            if (orphan)
                $display("unexpected result: st=%0d ov=%0d ob=%02h iu=%0d pc=%0d",
                         got.status, got.out_valid, got.out_byte, got.input_used,
                         got.program_counter);
            else
                $display({"result %0d: want st=%0d ov=%0d ob=%02h iu=%0d pc=%0d,",
                          " got st=%0d ov=%0d ob=%02h iu=%0d pc=%0d"},
                         n_checked, want.status, want.out_valid, want.out_byte,
                         want.input_used, want.program_counter, got.status,
                         got.out_valid, got.out_byte, got.input_used,
                         got.program_counter);
        end
    endtask

    always @(posedge clk) begin : driver
        t_out r;
        bit take;
        take = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                void'(machine_exec(1, in_item, 1'b0, r));
                result_q.push_back(r);
                take = 1'b1;
            end
            if (!in_valid || take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    in_item <= pending.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 29) == 0)
                        calm_in = !calm_in;
                    gap_left = gap_len(calm_in);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    want = '0;
                    note_miss(1'b1, want, o_out_data);
                end else begin
                    want = result_q.pop_front();
                    if (o_out_data.status !== want.status ||
                        o_out_data.out_valid !== want.out_valid ||
                        o_out_data.out_byte !== want.out_byte ||
                        o_out_data.input_used !== want.input_used ||
                        o_out_data.program_counter !== want.program_counter)
                        note_miss(1'b0, want, o_out_data);
                end
                n_checked++;
            end
            if ($urandom_range(0, 63) == 0)
                calm_out = !calm_out;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                hold_left = gap_len(calm_out);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("bf_tape_machine_step regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        string dprog;
        int i, base, restarts_left, dir_count, progs;
        bit ok, noisy;
        t_out r;
        t_in it;
        dprog = "<-.>,[-].";
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty program, no-op, field extremes, every command but +
        set_length(0);
        try_step(8'h00, ok, r);
        it.func = FUNC_NOP;
        it.load_address = '1;
        it.prog_char = '1;
        it.in_byte = '1;
        queue_item(it);
        queue_load(PROG_DEPTH - 1, 8'hFF);
        queue_load(0, 8'h00);
        for (i = 0; i < dprog.len(); i++)
            queue_load(i, dprog[i]);
        set_length(dprog.len());
        for (i = 0; i < 12; i++)
            try_step(8'd2, ok, r);

        // random: programs appended behind the last one, restart after errors or when program memory is full
        dir_count = n_queued;
        base = dprog.len();
        restarts_left = 8;
        progs = 0;
        while (n_queued - dir_count < RAND_ITEMS) begin
            noisy = restarts_left > 0 && $urandom_range(0, 4) == 0;
            build_program(noisy);
            if ((halted_m[0] && restarts_left > 0) ||
                base + prog_buf.size() > PROG_DEPTH) begin
                queue_item(rand_item(FUNC_RESTART));
                restarts_left--;
                base = 0;
            end
            for (i = 0; i < prog_buf.size(); i++)
                queue_load(base + i, prog_buf[i]);
            base += prog_buf.size();
            progs++;
            set_length((progs == 6) ? PROG_DEPTH : base);
            run_steps(3 * prog_buf.size() + 8);
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("bf_tape_machine_step regression: pass");
        else
            $display("bf_tape_machine_step regression: fail");
        $finish;
    end

endmodule
